// File: sv/cstl_pkg.sv
package cstl_pkg;

    localparam int unsigned SLOTS_DEFAULT    = 64;
    localparam int unsigned LIFETIME_W       = 16;
    localparam int unsigned SLOTS_CFG_W      = 7;
    localparam int unsigned CFG_DATA_W       = 16;
    localparam int unsigned SLOT_OUT_W       = 6;
    localparam int unsigned COUNT_OUT_W      = 7;

    localparam logic [LIFETIME_W-1:0]  LIFETIME_RESET = 16'd20;
    localparam logic [SLOTS_CFG_W-1:0] SLOTS_RESET    = 7'd64;

    localparam logic [1:0] ACT_FIND  = 2'd0;
    localparam logic [1:0] ACT_OPEN  = 2'd1;
    localparam logic [1:0] ACT_CLOSE = 2'd2;
    localparam logic [1:0] ACT_PURGE = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    localparam logic CFG_LIFETIME = 1'b0;
    localparam logic CFG_SLOTS    = 1'b1;

    typedef struct packed {
        logic [15:0] key;
        logic [31:0] addr;
        logic        known;
        logic [31:0] dl_sec;
        logic [29:0] dl_nsec;
    } t_entry;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
    } t_sts;

endpackage

// File: sv/connection_slot_table_with_lifetime.sv
// An action runs from start to the o_valid strobe through a load step, a scan of the slots
// (up to the active slot count, fewer when find, open or close hits) and a final step.
// One transfer at a time: busy drops with the result strobe, and a new start is accepted
// only while busy is low. One slot is scanned per cycle through the single read port of
// the slot memory. Reset is synchronous and active low: all slots become free and the
// configuration registers take their defaults. Results are shown for one cycle; the
// receiver cannot stall.
module connection_slot_table_with_lifetime
    import cstl_pkg::*;
#(
    parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_action,
    input  logic [15:0]            i_conn_key,
    input  logic [31:0]            i_peer_addr,
    input  logic                   i_peer_known,
    input  logic [31:0]            i_now_sec,
    input  logic [29:0]            i_now_nsec,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output logic                   o_valid,
    output logic [1:0]             o_status,
    output logic [SLOT_OUT_W-1:0]  o_slot,
    output logic [31:0]            o_slot_peer,
    output logic                   o_slot_peer_known,
    output logic [COUNT_OUT_W-1:0] o_closed_count
);

    t_cmd cmd;
    t_sts sts;

    cstl_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_sts  (sts),
        .o_cmd  (cmd)
    );

    cstl_dp #(
        .SLOTS(SLOTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_action         (i_action),
        .i_conn_key       (i_conn_key),
        .i_peer_addr      (i_peer_addr),
        .i_peer_known     (i_peer_known),
        .i_now_sec        (i_now_sec),
        .i_now_nsec       (i_now_nsec),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_slot           (o_slot),
        .o_slot_peer      (o_slot_peer),
        .o_slot_peer_known(o_slot_peer_known),
        .o_closed_count   (o_closed_count)
    );

endmodule

// File: sv/cstl_ram.sv
module cstl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/cstl_ctrl.sv
module cstl_ctrl
    import cstl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_FINAL = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

// File: sv/cstl_dp.sv
module cstl_dp
    import cstl_pkg::*;
#(
    parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    input  logic [1:0]             i_action,
    input  logic [15:0]            i_conn_key,
    input  logic [31:0]            i_peer_addr,
    input  logic                   i_peer_known,
    input  logic [31:0]            i_now_sec,
    input  logic [29:0]            i_now_nsec,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output logic                   o_valid,
    output logic [1:0]             o_status,
    output logic [SLOT_OUT_W-1:0]  o_slot,
    output logic [31:0]            o_slot_peer,
    output logic                   o_slot_peer_known,
    output logic [COUNT_OUT_W-1:0] o_closed_count
);

    localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CW = $clog2(SLOTS + 1);
    localparam int unsigned MW = (CW > SLOTS_CFG_W) ? CW : SLOTS_CFG_W;

    logic [LIFETIME_W-1:0]  r_lifetime;
    logic [SLOTS_CFG_W-1:0] r_slots_in_use;

    logic [1:0]  r_action;
    logic [15:0] r_key;
    logic [31:0] r_addr;
    logic        r_known;
    logic [31:0] r_sec;
    logic [29:0] r_nsec;

    logic [SLOTS-1:0] r_slot_valid;
    logic [CW-1:0]    r_n;
    logic [CW-1:0]    r_idx;
    logic             r_p_live;
    logic [IW-1:0]    r_p_idx;
    logic             r_hit;
    logic [IW-1:0]    r_hit_idx;
    logic [31:0]      r_hit_peer;
    logic             r_hit_known;
    logic [CW-1:0]    r_count;

    logic                   r_valid;
    logic [1:0]             r_status;
    logic [SLOT_OUT_W-1:0]  r_slot;
    logic [31:0]            r_slot_peer;
    logic                   r_slot_peer_known;
    logic [COUNT_OUT_W-1:0] r_closed_count;

    t_entry        rd_entry;
    t_entry        wr_entry;
    logic          ram_we;
    logic [MW-1:0] cfg_n_ext;
    logic [MW-1:0] slots_ext;
    logic [CW-1:0] eff_n;
    logic          p_valid;
    logic          expired;
    logic          match;
    logic          hit_now;
    logic          more;
    logic          issue;
    logic [31:0]   open_peer;

    assign cfg_n_ext = MW'(r_slots_in_use);
    assign slots_ext = MW'(SLOTS);
    assign eff_n     = (cfg_n_ext > slots_ext) ? CW'(slots_ext) : CW'(cfg_n_ext);

    assign p_valid = r_slot_valid[r_p_idx];
    assign expired = (r_sec > rd_entry.dl_sec) ||
                     ((r_sec == rd_entry.dl_sec) && (r_nsec >= rd_entry.dl_nsec));

    always_comb begin
        unique case (r_action)
            ACT_FIND:  match = p_valid && (rd_entry.key == r_key);
            ACT_OPEN:  match = !p_valid;
            ACT_CLOSE: match = p_valid && (rd_entry.key == r_key);
            default:   match = p_valid && expired;
        endcase
    end

    assign hit_now = i_cmd.scan && r_p_live && match && (r_action != ACT_PURGE);
    assign more    = (r_idx < r_n) && !r_hit;
    assign issue   = i_cmd.scan && more && !hit_now;
    assign o_sts.scan_done = !r_p_live && !more;

    assign open_peer = r_known ? r_addr : 32'd0;
    assign ram_we    = i_cmd.finish && r_hit && (r_action == ACT_OPEN);

    always_comb begin
        wr_entry         = '0;
        wr_entry.key     = r_key;
        wr_entry.addr    = open_peer;
        wr_entry.known   = r_known;
        wr_entry.dl_sec  = r_sec + 32'(r_lifetime);
        wr_entry.dl_nsec = r_nsec;
    end

    cstl_ram #(
        .WIDTH($bits(t_entry)),
        .DEPTH(SLOTS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_hit_idx),
        .i_wdata(wr_entry),
        .i_raddr(r_idx[IW-1:0]),
        .o_rdata(rd_entry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lifetime     <= LIFETIME_RESET;
            r_slots_in_use <= SLOTS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LIFETIME: r_lifetime     <= i_cfg_data[LIFETIME_W-1:0];
                CFG_SLOTS:    r_slots_in_use <= i_cfg_data[SLOTS_CFG_W-1:0];
                default:      r_lifetime     <= r_lifetime;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_key    <= i_conn_key;
            r_addr   <= i_peer_addr;
            r_known  <= i_peer_known;
            r_sec    <= i_now_sec;
            r_nsec   <= i_now_nsec;
            r_n      <= eff_n;
        end
        if (issue) begin
            r_p_idx <= r_idx[IW-1:0];
        end
        if (hit_now) begin
            r_hit_idx   <= r_p_idx;
            r_hit_peer  <= rd_entry.addr;
            r_hit_known <= rd_entry.known;
        end
        if (i_cmd.finish) begin
            if (r_action == ACT_PURGE) begin
                r_status          <= ST_OK;
                r_slot            <= '0;
                r_slot_peer       <= '0;
                r_slot_peer_known <= 1'b0;
                r_closed_count    <= COUNT_OUT_W'(r_count);
            end else if (!r_hit) begin
                r_status          <= (r_action == ACT_OPEN) ? ST_FULL : ST_NOT_FOUND;
                r_slot            <= '0;
                r_slot_peer       <= '0;
                r_slot_peer_known <= 1'b0;
                r_closed_count    <= '0;
            end else begin
                r_status          <= ST_OK;
                r_slot            <= SLOT_OUT_W'(r_hit_idx);
                r_slot_peer       <= (r_action == ACT_OPEN) ? open_peer : r_hit_peer;
                r_slot_peer_known <= (r_action == ACT_OPEN) ? r_known : r_hit_known;
                r_closed_count    <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            r_idx        <= '0;
            r_p_live     <= 1'b0;
            r_hit        <= 1'b0;
            r_count      <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
            if (i_cmd.load) begin
                r_idx    <= '0;
                r_p_live <= 1'b0;
                r_hit    <= 1'b0;
                r_count  <= '0;
            end else if (i_cmd.scan) begin
                r_p_live <= issue;
                if (issue) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (hit_now) begin
                    r_hit <= 1'b1;
                end
                if (r_p_live && match && (r_action == ACT_PURGE)) begin
                    r_slot_valid[r_p_idx] <= 1'b0;
                    r_count               <= r_count + 1'b1;
                end
            end else if (i_cmd.finish && r_hit) begin
                if (r_action == ACT_OPEN) begin
                    r_slot_valid[r_hit_idx] <= 1'b1;
                end else if (r_action == ACT_CLOSE) begin
                    r_slot_valid[r_hit_idx] <= 1'b0;
                end
            end
        end
    end

    assign o_valid           = r_valid;
    assign o_status          = r_status;
    assign o_slot            = r_slot;
    assign o_slot_peer       = r_slot_peer;
    assign o_slot_peer_known = r_slot_peer_known;
    assign o_closed_count    = r_closed_count;

endmodule

// File: bench/connection_slot_table_with_lifetime_test.sv
`timescale 1ns / 1ps

module connection_slot_table_with_lifetime_test;
    import cstl_pkg::*;

    localparam int SLOT_COUNT   = SLOTS_DEFAULT;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = SLOT_COUNT + 8;

    typedef struct packed {
        logic [1:0]             status;
        logic [SLOT_OUT_W-1:0]  slot;
        logic [31:0]            peer;
        logic                   peer_known;
        logic [COUNT_OUT_W-1:0] closed;
    } t_conn_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic [1:0]             i_action = ACT_FIND;
    logic [15:0]            i_conn_key = '0;
    logic [31:0]            i_peer_addr = '0;
    logic                   i_peer_known = 1'b0;
    logic [31:0]            i_now_sec = '0;
    logic [29:0]            i_now_nsec = '0;
    logic                   i_cfg_we = 1'b0;
    logic                   i_cfg_idx = CFG_LIFETIME;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   busy;
    logic                   o_valid;
    logic [1:0]             o_status;
    logic [SLOT_OUT_W-1:0]  o_slot;
    logic [31:0]            o_slot_peer;
    logic                   o_slot_peer_known;
    logic [COUNT_OUT_W-1:0] o_closed_count;

    bit          slot_used [SLOT_COUNT];
    logic [15:0] slot_key [SLOT_COUNT];
    logic [31:0] slot_addr [SLOT_COUNT];
    logic        slot_known [SLOT_COUNT];
    logic [31:0] slot_dl_sec [SLOT_COUNT];
    logic [29:0] slot_dl_nsec [SLOT_COUNT];

    logic [LIFETIME_W-1:0]  cfg_lifetime = LIFETIME_RESET;
    logic [SLOTS_CFG_W-1:0] cfg_slots = SLOTS_RESET;

    t_conn_result pending_answers[$];
    t_conn_result answer_head;
    int           errors = 0;
    int           stall_cycles = 0;
    int           sender_idle_pct = 0;
    logic [31:0]  clock_sec = 32'd1000;
    logic [29:0]  clock_nsec = '0;

    connection_slot_table_with_lifetime #(
        .SLOTS(SLOT_COUNT)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_action(i_action),
        .i_conn_key(i_conn_key),
        .i_peer_addr(i_peer_addr),
        .i_peer_known(i_peer_known),
        .i_now_sec(i_now_sec),
        .i_now_nsec(i_now_nsec),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .o_valid(o_valid),
        .o_status(o_status),
        .o_slot(o_slot),
        .o_slot_peer(o_slot_peer),
        .o_slot_peer_known(o_slot_peer_known),
        .o_closed_count(o_closed_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_conn_result predict_action(input logic [1:0] act,
                                                    input logic [15:0] key,
                                                    input logic [31:0] addr,
                                                    input logic known,
                                                    input logic [31:0] sec,
                                                    input logic [29:0] nsec);
        t_conn_result res;
        int           active;
        int           hit;
        int           freed;
        res = '0;
        res.status = ST_OK;
        active = (cfg_slots > SLOT_COUNT) ? SLOT_COUNT : int'(cfg_slots);
        hit = -1;
        freed = 0;
        case (act)
            ACT_FIND, ACT_CLOSE: begin
                for (int i = 0; i < active; i++) begin
                    if (hit < 0 && slot_used[i] && slot_key[i] == key) hit = i;
                end
            end
            ACT_OPEN: begin
                for (int i = 0; i < active; i++) begin
                    if (hit < 0 && !slot_used[i]) hit = i;
                end
                if (hit >= 0) begin
                    slot_used[hit] = 1'b1;
                    slot_key[hit] = key;
                    slot_addr[hit] = known ? addr : 32'd0;
                    slot_known[hit] = known;
                    slot_dl_sec[hit] = sec + {16'd0, cfg_lifetime};
                    slot_dl_nsec[hit] = nsec;
                end
            end
            default: begin
                for (int i = 0; i < active; i++) begin
                    if (slot_used[i] && (sec > slot_dl_sec[i] ||
                        (sec == slot_dl_sec[i] && nsec >= slot_dl_nsec[i]))) begin
                        slot_used[i] = 1'b0;
                        freed++;
                    end
                end
                res.closed = COUNT_OUT_W'(freed);
            end
        endcase
        if (act != ACT_PURGE) begin
            if (hit < 0) begin
                res.status = (act == ACT_OPEN) ? ST_FULL : ST_NOT_FOUND;
            end else begin
                res.slot = SLOT_OUT_W'(hit);
                res.peer = slot_addr[hit];
                res.peer_known = slot_known[hit];
                if (act == ACT_CLOSE) slot_used[hit] = 1'b0;
            end
        end
        return res;
    endfunction

    task automatic send_action(input logic [1:0] act, input logic [15:0] key,
                               input logic [31:0] addr, input logic known,
                               input logic [31:0] sec, input logic [29:0] nsec);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_action <= act;
        i_conn_key <= key;
        i_peer_addr <= addr;
        i_peer_known <= known;
        i_now_sec <= sec;
        i_now_nsec <= nsec;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_answers.push_back(predict_action(act, key, addr, known, sec, nsec));
    endtask

    task automatic write_register(input logic idx, input logic [CFG_DATA_W-1:0] data);
        start <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == CFG_LIFETIME) cfg_lifetime = data[LIFETIME_W-1:0];
        else cfg_slots = data[SLOTS_CFG_W-1:0];
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_answers.size() == 0) begin
                $error("result transfer with no action outstanding");
                errors++;
            end else begin
                answer_head = pending_answers.pop_front();
                check_field("status", 32'(answer_head.status), 32'(o_status));
                check_field("slot", 32'(answer_head.slot), 32'(o_slot));
                check_field("slot_peer", answer_head.peer, o_slot_peer);
                check_field("slot_peer_known", 32'(answer_head.peer_known),
                            32'(o_slot_peer_known));
                check_field("closed_count", 32'(answer_head.closed), 32'(o_closed_count));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_valid === 1'b1 || i_cfg_we) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic test_empty_table();
        send_action(ACT_FIND, 16'h0000, 32'd0, 1'b0, 32'd0, 30'd0);
        send_action(ACT_CLOSE, 16'hFFFF, 32'd0, 1'b0, 32'd0, 30'd0);
        send_action(ACT_PURGE, 16'h0000, 32'd0, 1'b0, 32'hFFFF_FFFF, 30'h3FFF_FFFF);
    endtask

    task automatic test_open_find_close();
        send_action(ACT_OPEN, 16'h0000, 32'hFFFF_FFFF, 1'b1, 32'd100, 30'd5);
        send_action(ACT_OPEN, 16'hFFFF, 32'h1234_5678, 1'b0, 32'd100, 30'h3FFF_FFFF);
        send_action(ACT_OPEN, 16'h0000, 32'h0000_0000, 1'b1, 32'd100, 30'd5);
        send_action(ACT_FIND, 16'h0000, 32'd0, 1'b0, 32'd101, 30'd0);
        send_action(ACT_CLOSE, 16'h0000, 32'd0, 1'b0, 32'd101, 30'd0);
        send_action(ACT_FIND, 16'h0000, 32'd0, 1'b0, 32'd101, 30'd0);
        send_action(ACT_FIND, 16'hFFFF, 32'd0, 1'b0, 32'd101, 30'd0);
    endtask

    task automatic test_deadline_edges();
        send_action(ACT_PURGE, 16'd0, 32'd0, 1'b0, 32'd120, 30'd4);
        send_action(ACT_PURGE, 16'd0, 32'd0, 1'b0, 32'd120, 30'd5);
        send_action(ACT_PURGE, 16'd0, 32'd0, 1'b0, 32'd120, 30'h3FFF_FFFF);
    endtask

    task automatic test_lifetime_wrap();
        write_register(CFG_LIFETIME, 16'hFFFF);
        send_action(ACT_OPEN, 16'd7, 32'hC0A8_0001, 1'b1, 32'hFFFF_FFF0, 30'd0);
        send_action(ACT_PURGE, 16'd0, 32'd0, 1'b0, 32'hFFFF_FFF0, 30'd0);
        write_register(CFG_LIFETIME, 16'h0000);
        send_action(ACT_OPEN, 16'd8, 32'h0A00_0001, 1'b1, 32'd50, 30'd999999999);
        send_action(ACT_PURGE, 16'd0, 32'd0, 1'b0, 32'd50, 30'd999999998);
        send_action(ACT_PURGE, 16'd0, 32'd0, 1'b0, 32'd50, 30'd999999999);
    endtask

    task automatic test_slot_limit();
        write_register(CFG_LIFETIME, 16'd20);
        write_register(CFG_SLOTS, 16'd2);
        send_action(ACT_OPEN, 16'd3, 32'h0101_0101, 1'b1, 32'd200, 30'd0);
        send_action(ACT_OPEN, 16'd4, 32'h0202_0202, 1'b1, 32'd200, 30'd0);
        send_action(ACT_OPEN, 16'd5, 32'h0303_0303, 1'b1, 32'd200, 30'd0);
        write_register(CFG_SLOTS, 16'd1);
        send_action(ACT_FIND, 16'd4, 32'd0, 1'b0, 32'd201, 30'd0);
        write_register(CFG_SLOTS, 16'hFF7F);
        send_action(ACT_FIND, 16'd4, 32'd0, 1'b0, 32'd201, 30'd0);
        write_register(CFG_SLOTS, 16'd0);
        send_action(ACT_OPEN, 16'd6, 32'h0404_0404, 1'b1, 32'd201, 30'd0);
        send_action(ACT_FIND, 16'd3, 32'd0, 1'b0, 32'd201, 30'd0);
        send_action(ACT_PURGE, 16'd0, 32'd0, 1'b0, 32'hFFFF_FFFF, 30'h3FFF_FFFF);
        write_register(CFG_SLOTS, 16'd64);
        send_action(ACT_PURGE, 16'd0, 32'd0, 1'b0, 32'hFFFF_FFFF, 30'h3FFF_FFFF);
    endtask

    task automatic run_traffic_phase(input int items, input int idle_pct);
        int          roll;
        logic [1:0]  act;
        logic [15:0] key;
        sender_idle_pct = idle_pct;
        repeat (items) begin
            roll = $urandom_range(99);
            if (roll < 25) act = ACT_FIND;
            else if (roll < 60) act = ACT_OPEN;
            else if (roll < 85) act = ACT_CLOSE;
            else act = ACT_PURGE;
            key = ($urandom_range(9) < 8) ? 16'($urandom_range(7)) : 16'($urandom);
            if ($urandom_range(19) == 0) clock_sec = $urandom;
            else clock_sec = clock_sec + $urandom_range(3);
            if ($urandom_range(19) == 0) clock_nsec = 30'($urandom);
            else if ($urandom_range(4) != 0) clock_nsec = 30'($urandom_range(999999999));
            send_action(act, key, $urandom, 1'($urandom), clock_sec, clock_nsec);
        end
    endtask

    task automatic test_random_traffic();
        write_register(CFG_LIFETIME, 16'd5);
        write_register(CFG_SLOTS, 16'd64);
        run_traffic_phase(200, 18);
        write_register(CFG_LIFETIME, 16'd0);
        write_register(CFG_SLOTS, {9'($urandom), 7'd5});
        run_traffic_phase(200, 59);
        write_register(CFG_LIFETIME, 16'hFFFF);
        write_register(CFG_SLOTS, 16'd127);
        run_traffic_phase(200, 0);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_table();
        test_open_find_close();
        test_deadline_edges();
        test_lifetime_wrap();
        test_slot_limit();
        test_random_traffic();
        start <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/cstl_pkg.sv
sv/cstl_ram.sv
sv/cstl_ctrl.sv
sv/cstl_dp.sv
sv/connection_slot_table_with_lifetime.sv
bench/connection_slot_table_with_lifetime_test.sv
